/* src/rdc_pkg.sv */
`timescale 1ns / 1ps
package rdc_pkg;

  // Cache geometry
  localparam int SETS       = 2048;
  localparam int SET_W      = 11;
  localparam int WAYS       = 16;
  localparam int WAYIX_W    = 4;
  localparam int WAY_W      = 5;
  localparam int ETR_W      = 5;
  localparam int ROW_W      = WAYS * ETR_W;

  // Estimated-time-to-reuse and reuse-distance limits
  localparam int INF_ETR    = 15;
  localparam int INF_RD     = 127;
  localparam int MAX_RD     = 105;
  localparam int AGE_PERIOD = 8;

  // Sampler: 32 sampled sets, 16 subsets each, 5 entries per row
  localparam int SMP_WAYS   = 5;
  localparam int SMP_ROWS   = 512;
  localparam int SMP_ROW_AW = 9;
  localparam int TAG_W      = 10;
  localparam int SIG_W      = 11;
  localparam int TS_W       = 8;
  localparam int SMP_E_W    = 1 + TAG_W + SIG_W + TS_W;
  localparam int SMP_ROW_W  = SMP_WAYS * SMP_E_W;
  localparam int SLOT_W     = 3;

  // Per-set state word: {aging clock, timestamp}
  localparam int AGE_W      = 4;
  localparam int SS_W       = AGE_W + TS_W;

  // Predictor word: {valid, distance}
  localparam int DIST_W     = 8;
  localparam int PRED_W     = 1 + DIST_W;
  localparam int PRED_DEPTH = 2048;

  localparam logic [63:0] CRC_POLY = 64'hEDB8_8320;

  // Codes
  localparam logic       ACT_VICTIM     = 1'b0;
  localparam logic       ACT_UPDATE     = 1'b1;
  localparam logic [1:0] KIND_PREFETCH  = 2'd1;
  localparam logic [1:0] KIND_WRITE     = 2'd2;
  localparam logic       REG_LOG2_CORES = 1'b0;

  typedef struct packed {
    logic             clr;
    logic             load;
    logic             rd;
    logic             scan;
    logic             smp_wr;
    logic             prd_rd;
    logic             prd_wr;
    logic             fin_rd;
    logic             apply;
    logic             out_load;
    logic [SET_W-1:0] idx;
  } rdc_cmd_t;

  typedef struct packed {
    logic is_update;
    logic is_write;
    logic sampled;
  } rdc_sts_t;

  // Three CRC steps over the packed signature word
  function automatic logic [SIG_W-1:0] sig_hash(input logic [63:0] pc, input logic hit,
                                                input logic pf, input logic [1:0] core,
                                                input logic [1:0] l2c);
    logic [63:0] x;
    x = (l2c == 2'd0) ? {pc[61:0], hit, pf} : {pc[60:0], pf, core};
    for (int i = 0; i < 3; i++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x[SIG_W-1:0];
  endfunction

  function automatic logic [ETR_W-1:0] etr_mag(input logic [ETR_W-1:0] v);
    return v[ETR_W-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

/* src/reuse_distance_cache_replacement.sv */
`timescale 1ns / 1ps
// Channel  Handshake                  Word
// in       in_valid_i / in_ready_o    action, core, set_index, way, address, pc, kind, hit
// out      out_valid_o / out_ready_i  evict_way
// cfg      psel/penable/pwrite/pready log2_cores at byte address 0
//
// Victim request: the set's counters are scanned one way per cycle.
// Update: on a sampled set, other than a write, six predictor read/write pairs run.
// After reset a clearing pass runs over all stores; no word is taken then.
// One word is in flight at a time; a finished result waits in the output register
// while the next word is taken, and the next result holds until that one is taken.
module reuse_distance_cache_replacement
  import rdc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             action_i,
  input  logic [1:0]       core_i,
  input  logic [SET_W-1:0] set_index_i,
  input  logic [WAY_W-1:0] way_i,
  input  logic [63:0]      address_i,
  input  logic [63:0]      pc_i,
  input  logic [1:0]       access_kind_i,
  input  logic             hit_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WAY_W-1:0] evict_way_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  rdc_cmd_t   cmd;
  rdc_sts_t   sts;
  logic       cfg_we;
  logic [1:0] l2c;

  // Register port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_LOG2_CORES);
  assign prdata = (paddr[2] == REG_LOG2_CORES) ? {30'b0, l2c} : '0;

  rdc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd));

  rdc_dpath u_dpath (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .action_i, .core_i, .set_index_i,
    .way_i, .address_i, .pc_i, .access_kind_i, .hit_i, .cfg_we_i(cfg_we),
    .cfg_wdata_i(pwdata[1:0]), .log2_cores_o(l2c), .evict_way_o);

endmodule

/* src/rdc_ram.sv */
`timescale 1ns / 1ps
module rdc_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic                 re_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/rdc_ctrl.sv */
`timescale 1ns / 1ps
module rdc_ctrl
  import rdc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  rdc_sts_t sts_i,
  output rdc_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD, S_SCAN, S_SMP, S_PRD_RD, S_PRD_WR, S_FIN_RD, S_APPLY, S_DONE
  } state_e;

  state_e           state_q;
  logic [SET_W-1:0] idx_q;
  logic             out_valid_q;

  // Commands decoded from the state
  always_comb begin
    cmd_o          = '0;
    cmd_o.idx      = idx_q;
    cmd_o.clr      = (state_q == S_CLR);
    cmd_o.load     = (state_q == S_IDLE) && in_valid_i;
    cmd_o.rd       = (state_q == S_RD);
    cmd_o.scan     = (state_q == S_SCAN);
    cmd_o.smp_wr   = (state_q == S_SMP);
    cmd_o.prd_rd   = (state_q == S_PRD_RD);
    cmd_o.prd_wr   = (state_q == S_PRD_WR);
    cmd_o.fin_rd   = (state_q == S_FIN_RD);
    cmd_o.apply    = (state_q == S_APPLY);
    cmd_o.out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // result register: set on completion, cleared when taken
      if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLR: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == SET_W'(SETS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_RD;
          end
        end
        S_RD: begin
          if (!sts_i.is_update) begin
            idx_q   <= SET_W'(1);
            state_q <= S_SCAN;
          end else if (!sts_i.is_write && sts_i.sampled) begin
            state_q <= S_SMP;
          end else begin
            state_q <= S_APPLY;
          end
        end
        S_SCAN: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q[WAYIX_W-1:0] == WAYIX_W'(WAYS - 1)) begin
            state_q <= S_DONE;
          end
        end
        S_SMP: begin
          idx_q   <= '0;
          state_q <= S_PRD_RD;
        end
        S_PRD_RD: state_q <= S_PRD_WR;
        S_PRD_WR: begin
          if (idx_q[SLOT_W-1:0] == SLOT_W'(SMP_WAYS)) begin
            state_q <= S_FIN_RD;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_PRD_RD;
          end
        end
        S_FIN_RD: state_q <= S_APPLY;
        S_APPLY:  state_q <= S_DONE;
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_RD)
    else $error("accepted word not followed by read");
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside completion");
  a_prd_pairs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PRD_WR |-> $past(state_q == S_PRD_RD))
    else $error("predictor write without read");
`endif

endmodule

/* src/rdc_dpath.sv */
`timescale 1ns / 1ps
module rdc_dpath
  import rdc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rdc_cmd_t         cmd_i,
  output rdc_sts_t         sts_o,
  input  logic             action_i,
  input  logic [1:0]       core_i,
  input  logic [SET_W-1:0] set_index_i,
  input  logic [WAY_W-1:0] way_i,
  input  logic [63:0]      address_i,
  input  logic [63:0]      pc_i,
  input  logic [1:0]       access_kind_i,
  input  logic             hit_i,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_wdata_i,
  output logic [1:0]       log2_cores_o,
  output logic [WAY_W-1:0] evict_way_o
);

  // Captured word
  logic             act_q, hit_q, pf_q, wr_q;
  logic [1:0]       core_q, l2c_q;
  logic [SET_W-1:0] set_q;
  logic [WAY_W-1:0] way_q;
  logic [TAG_W-1:0] tag_q;
  logic [3:0]       sub_q;
  logic [63:0]      pc_q;
  logic [WAYIX_W-1:0] best_q;
  logic [WAY_W-1:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l2c_q <= '0;
    end else if (cfg_we_i) begin
      l2c_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= action_i;
      core_q <= core_i;
      set_q  <= set_index_i;
      way_q  <= way_i;
      tag_q  <= address_i[30:21];
      sub_q  <= address_i[20:17];
      pc_q   <= pc_i;
      pf_q   <= (access_kind_i == KIND_PREFETCH);
      wr_q   <= (access_kind_i == KIND_WRITE);
      hit_q  <= hit_i;
    end
  end

  logic [SIG_W-1:0]      sig;
  logic                  sampled;
  logic [SMP_ROW_AW-1:0] smp_addr;

  assign sig      = sig_hash(pc_q, act_q & hit_q, pf_q, core_q, l2c_q);
  assign sampled  = (set_q[5:0] == set_q[10:5]);
  assign smp_addr = {set_q[10:6], sub_q};
  assign sts_o    = '{is_update: (act_q == ACT_UPDATE), is_write: wr_q, sampled: sampled};

  // Stores
  logic [ROW_W-1:0]     row_rd, row_wd;
  logic [SS_W-1:0]      ss_rd, ss_wd;
  logic [SMP_ROW_W-1:0] smp_rd, smp_wd;
  logic [PRED_W-1:0]    pred_rd, pred_wd, op_new;
  logic [SIG_W-1:0]     op_sig, pred_raddr, pred_waddr;
  logic                 op_flag;

  rdc_ram #(.W(ROW_W), .D(SETS)) u_row_ram (
    .clk_i, .we_i(cmd_i.clr | cmd_i.apply), .waddr_i(cmd_i.clr ? cmd_i.idx : set_q),
    .wdata_i(row_wd), .re_i(cmd_i.rd), .raddr_i(set_q), .rdata_o(row_rd));

  rdc_ram #(.W(SS_W), .D(SETS)) u_ss_ram (
    .clk_i, .we_i(cmd_i.clr | (cmd_i.apply & ~wr_q)), .waddr_i(cmd_i.clr ? cmd_i.idx : set_q),
    .wdata_i(ss_wd), .re_i(cmd_i.rd), .raddr_i(set_q), .rdata_o(ss_rd));

  rdc_ram #(.W(SMP_ROW_W), .D(SMP_ROWS)) u_smp_ram (
    .clk_i, .we_i(cmd_i.clr | cmd_i.smp_wr),
    .waddr_i(cmd_i.clr ? cmd_i.idx[SMP_ROW_AW-1:0] : smp_addr),
    .wdata_i(cmd_i.clr ? '0 : smp_wd), .re_i(cmd_i.rd), .raddr_i(smp_addr),
    .rdata_o(smp_rd));

  assign pred_raddr = cmd_i.prd_rd ? op_sig : sig;
  assign pred_waddr = cmd_i.clr ? cmd_i.idx : op_sig;
  assign pred_wd    = cmd_i.clr ? '0 : op_new;

  rdc_ram #(.W(PRED_W), .D(PRED_DEPTH)) u_pred_ram (
    .clk_i, .we_i(cmd_i.clr | (cmd_i.prd_wr & op_flag)), .waddr_i(pred_waddr),
    .wdata_i(pred_wd), .re_i(cmd_i.rd | cmd_i.prd_rd | cmd_i.fin_rd),
    .raddr_i(pred_raddr), .rdata_o(pred_rd));

  // Sampler row evaluation
  logic [SMP_WAYS-1:0] ev, v1, v2, v3, exp_m, ins;
  logic [TAG_W-1:0]    etag [SMP_WAYS];
  logic [SIG_W-1:0]    esig [SMP_WAYS];
  logic [TS_W-1:0]     ets [SMP_WAYS];
  logic [TS_W-1:0]     ed [SMP_WAYS];
  logic [TS_W-1:0]     now, lru_d, fm_d;
  logic [SLOT_W-1:0]   fm, lru;
  logic                found, trained, any_v, any_inv;
  logic [3:0]          pen_mul;
  logic [11:0]         pen_prod;
  logic [DIST_W-1:0]   train_d;

  assign now = ss_rd[TS_W-1:0];

  always_comb begin
    found   = 1'b0;
    fm      = '0;
    any_v   = 1'b0;
    lru     = '0;
    lru_d   = '0;
    ins     = '0;
    for (int i = 0; i < SMP_WAYS; i++) begin
      ev[i]   = smp_rd[i*SMP_E_W + SMP_E_W - 1];
      etag[i] = smp_rd[i*SMP_E_W + SIG_W + TS_W +: TAG_W];
      esig[i] = smp_rd[i*SMP_E_W + TS_W +: SIG_W];
      ets[i]  = smp_rd[i*SMP_E_W +: TS_W];
      ed[i]   = now - ets[i];
    end
    // first tag match
    for (int i = 0; i < SMP_WAYS; i++) begin
      if (!found && ev[i] && etag[i] == tag_q) begin
        found = 1'b1;
        fm    = SLOT_W'(i);
      end
    end
    fm_d    = ed[fm];
    trained = found && (fm_d <= TS_W'(INF_RD));
    v1      = ev;
    if (trained) v1[fm] = 1'b0;
    // expiry and oldest live entry
    for (int i = 0; i < SMP_WAYS; i++) begin
      exp_m[i] = v1[i] && (ed[i] > TS_W'(INF_RD));
    end
    v2      = v1 & ~exp_m;
    any_inv = |(~v2);
    for (int i = 0; i < SMP_WAYS; i++) begin
      if (v2[i] && (!any_v || ed[i] > lru_d)) begin
        lru   = SLOT_W'(i);
        lru_d = ed[i];
        any_v = 1'b1;
      end
    end
    v3 = v2;
    if (!any_inv) begin
      v3[lru]    = 1'b0;
      exp_m[lru] = 1'b1;
    end
    // insertion at the first free entry
    found = 1'b0;
    for (int i = 0; i < SMP_WAYS; i++) begin
      if (!found && !v3[i]) begin
        found  = 1'b1;
        ins[i] = 1'b1;
      end
    end
    for (int i = 0; i < SMP_WAYS; i++) begin
      smp_wd[i*SMP_E_W +: SMP_E_W] = ins[i] ? {1'b1, tag_q, sig, now}
                                            : {v3[i], etag[i], esig[i], ets[i]};
    end
  end

  // Prefetch penalty: d * (8 - log2_cores) / 4, truncated
  assign pen_mul  = 4'd8 - {2'b00, l2c_q};
  assign pen_prod = {4'b0, fm_d} * {8'b0, pen_mul};
  assign train_d  = pf_q ? pen_prod[9:2] : fm_d;

  // Predictor operation for the current slot: train first, then expiries
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] eix;
  logic [DIST_W-1:0] pd, inc;
  logic              pv;

  assign slot = cmd_i.idx[SLOT_W-1:0];
  assign eix  = (slot == '0) ? '0 : slot - 1'b1;
  assign pv   = pred_rd[PRED_W-1];
  assign pd   = pred_rd[DIST_W-1:0];
  assign inc  = pd + 1'b1;

  always_comb begin
    if (slot == '0) begin
      op_sig  = esig[fm];
      op_flag = trained;
      if (!pv) begin
        op_new = {1'b1, train_d};
      end else if (train_d > pd) begin
        op_new = {1'b1, pd + DIST_W'(((train_d - pd) >= DIST_W'(16)) ? 1 : 0)};
        if (op_new[DIST_W-1:0] > DIST_W'(INF_RD)) op_new = {1'b1, DIST_W'(INF_RD)};
      end else if (train_d < pd) begin
        op_new = {1'b1, pd - DIST_W'(((pd - train_d) >= DIST_W'(16)) ? 1 : 0)};
      end else begin
        op_new = {1'b1, pd};
      end
    end else begin
      op_sig  = esig[eix];
      op_flag = exp_m[eix];
      if (!pv || inc > DIST_W'(INF_RD)) begin
        op_new = {1'b1, DIST_W'(INF_RD)};
      end else begin
        op_new = {1'b1, inc};
      end
    end
  end

  // Row update: ageing, then load of the touched way; a write only marks a missed way.
  logic [ETR_W-1:0] etr [WAYS];
  logic [ETR_W-1:0] fill;
  logic [AGE_W-1:0] age, age_nx;
  logic             age_now;

  assign age     = ss_rd[SS_W-1:TS_W];
  assign age_now = (age == AGE_W'(AGE_PERIOD));
  assign age_nx  = (age_now ? '0 : age) + 1'b1;

  always_comb begin
    if (!pv) fill = (l2c_q == 2'd0) ? '0 : ETR_W'(INF_ETR);
    else if (pd > DIST_W'(MAX_RD)) fill = ETR_W'(INF_ETR);
    else fill = pd[DIST_W-1:3];
  end

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      etr[w] = row_rd[w*ETR_W +: ETR_W];
    end
    row_wd = '0;
    if (!cmd_i.clr) begin
      for (int w = 0; w < WAYS; w++) begin
        row_wd[w*ETR_W +: ETR_W] = etr[w];
        if (wr_q) begin
          if (!hit_q && way_q == WAY_W'(w)) row_wd[w*ETR_W +: ETR_W] = -ETR_W'(INF_ETR);
        end else begin
          if (age_now && way_q != WAY_W'(w) && etr_mag(etr[w]) < ETR_W'(INF_ETR)) begin
            row_wd[w*ETR_W +: ETR_W] = etr[w] - 1'b1;
          end
          if (way_q == WAY_W'(w)) row_wd[w*ETR_W +: ETR_W] = fill;
        end
      end
    end
  end

  assign ss_wd = cmd_i.clr ? {AGE_W'(AGE_PERIOD), TS_W'(0)}
                           : {age_nx, sampled ? now + 1'b1 : now};

  // Victim scan, one way per cycle
  logic [ETR_W-1:0] ma, mb;
  logic             bypass;

  assign ma = etr_mag(etr[cmd_i.idx[WAYIX_W-1:0]]);
  assign mb = etr_mag(etr[best_q]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      best_q <= '0;
    end else if (cmd_i.scan) begin
      if (ma > mb || (ma == mb && etr[cmd_i.idx[WAYIX_W-1:0]][ETR_W-1])) begin
        best_q <= cmd_i.idx[WAYIX_W-1:0];
      end
    end
  end

  assign bypass = !wr_q && pv && (pd > DIST_W'(MAX_RD) || pd[DIST_W-1:3] > mb);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= (act_q == ACT_VICTIM) ? (bypass ? WAY_W'(WAYS) : {1'b0, best_q}) : '0;
    end
  end

  assign evict_way_o  = out_q;
  assign log2_cores_o = l2c_q;

endmodule
